>>> hdl/i2cdws_pkg.sv
package i2cdws_pkg;

   localparam logic [0:0] ACT_BEGIN  = 1'b0;
   localparam logic [0:0] ACT_STATUS = 1'b1;

   localparam logic [2:0] ST_START     = 3'd0;
   localparam logic [2:0] ST_REP_START = 3'd1;
   localparam logic [2:0] ST_ADDR_ACK  = 3'd2;
   localparam logic [2:0] ST_ADDR_NACK = 3'd3;
   localparam logic [2:0] ST_DATA_ACK  = 3'd4;
   localparam logic [2:0] ST_ARB_LOST  = 3'd5;
   localparam logic [2:0] ST_OTHER     = 3'd6;

   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_SEND  = 2'd2;
   localparam logic [1:0] CMD_STOP  = 2'd3;

   localparam logic [7:0] CTRL_EEPROM = 8'h60;
   localparam logic [7:0] CTRL_DAC    = 8'h40;

   localparam logic [7:0] TRY_LIMIT_RESET = 8'd3;

   typedef struct packed {
      logic [0:0]  action;
      logic [7:0]  dev_address;
      logic [15:0] dac_value;
      logic [0:0]  eeprom_too;
      logic [2:0]  bus_status;
   } req_type;

   typedef struct packed {
      logic [1:0] bus_command;
      logic [7:0] tx_byte;
      logic [0:0] done_res;
      logic [0:0] success;
   } rsp_type;

endpackage

>>> hdl/i2cdws_fsm.sv
module i2cdws_fsm (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  i2cdws_pkg::req_type item,
   input  logic [7:0]        try_limit,
   output i2cdws_pkg::rsp_type result
);
   import i2cdws_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_START = 4'd1,
      PH_ADDR  = 4'd2,
      PH_CTRL1 = 4'd3,
      PH_LO1   = 4'd4,
      PH_HI1   = 4'd5,
      PH_CTRL2 = 4'd6,
      PH_LO2   = 4'd7,
      PH_HI2   = 4'd8
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  attempts_ff, attempts_in;
   logic [7:0]  address_ff, address_in;
   logic [15:0] value_ff, value_in;
   logic        eeprom_ff, eeprom_in;
   logic [7:0]  att_base;
   logic        start_due;
   logic [7:0]  ctrl_byte;

   assign ctrl_byte = eeprom_ff ? CTRL_EEPROM : CTRL_DAC;

   always_comb begin
      phase_in    = phase_ff;
      attempts_in = attempts_ff;
      address_in  = address_ff;
      value_in    = value_ff;
      eeprom_in   = eeprom_ff;
      att_base    = attempts_ff;
      start_due   = 1'b0;
      result      = '0;
      if (item.action == ACT_BEGIN) begin
         address_in  = item.dev_address;
         value_in    = item.dac_value;
         eeprom_in   = item.eeprom_too;
         att_base    = '0;
         attempts_in = '0;
         start_due   = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_START: begin
               if (item.bus_status == ST_ARB_LOST) begin
                  start_due = 1'b1;
               end else if (item.bus_status == ST_START ||
                            item.bus_status == ST_REP_START) begin
                  phase_in           = PH_ADDR;
                  result.bus_command = CMD_SEND;
                  result.tx_byte     = address_ff;
               end else begin
                  phase_in           = PH_IDLE;
                  result.bus_command = CMD_STOP;
                  result.done_res    = 1'b1;
               end
            end
            PH_ADDR: begin
               if (item.bus_status == ST_ADDR_NACK || item.bus_status == ST_ARB_LOST) begin
                  start_due = 1'b1;
               end else if (item.bus_status == ST_ADDR_ACK) begin
                  phase_in           = PH_CTRL1;
                  result.bus_command = CMD_SEND;
                  result.tx_byte     = ctrl_byte;
               end else begin
                  phase_in           = PH_IDLE;
                  result.bus_command = CMD_STOP;
                  result.done_res    = 1'b1;
               end
            end
            PH_CTRL1, PH_LO1, PH_HI1, PH_CTRL2, PH_LO2, PH_HI2: begin
               if (item.bus_status != ST_DATA_ACK) begin
                  phase_in           = PH_IDLE;
                  result.bus_command = CMD_STOP;
                  result.done_res    = 1'b1;
               end else if (phase_ff == PH_HI2) begin
                  phase_in           = PH_IDLE;
                  result.bus_command = CMD_STOP;
                  result.done_res    = 1'b1;
                  result.success     = 1'b1;
               end else begin
                  result.bus_command = CMD_SEND;
                  unique case (phase_ff)
                     PH_CTRL1: begin
                        phase_in       = PH_LO1;
                        result.tx_byte = value_ff[7:0];
                     end
                     PH_LO1: begin
                        phase_in       = PH_HI1;
                        result.tx_byte = value_ff[15:8];
                     end
                     PH_HI1: begin
                        phase_in       = PH_CTRL2;
                        result.tx_byte = ctrl_byte;
                     end
                     PH_CTRL2: begin
                        phase_in       = PH_LO2;
                        result.tx_byte = value_ff[7:0];
                     end
                     default: begin
                        phase_in       = PH_HI2;
                        result.tx_byte = value_ff[15:8];
                     end
                  endcase
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      if (start_due) begin
         if (att_base >= try_limit) begin
            phase_in           = PH_IDLE;
            result.bus_command = CMD_NONE;
            result.done_res    = 1'b1;
         end else begin
            attempts_in        = att_base + 8'd1;
            phase_in           = PH_START;
            result.bus_command = CMD_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         attempts_ff <= '0;
         address_ff  <= '0;
         value_ff    <= '0;
         eeprom_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         attempts_ff <= attempts_in;
         address_ff  <= address_in;
         value_ff    <= value_in;
         eeprom_ff   <= eeprom_in;
      end
   end

endmodule

>>> hdl/i2c_dac_write_sequencer.sv
// Sequencer for one I2C master write to a DAC, driven beat by beat.
// The request channel (req_valid, req_stall, req_data) carries either a begin
// beat, which latches the address byte, the 16-bit value and the EEPROM flag,
// or a status beat that reports what the bus engine saw.
// Every request beat produces exactly one response beat on rsp_valid, rsp_stall
// and rsp_data: the next bus command, the byte to send, and the end flags.
// The csr_wr_en and csr_wr_data port writes the retry limit; write it only
// while no transaction beat is in flight.
// A request beat passes through one input register, then the phase logic
// feeding the response register, before its response can be taken.
// One beat per cycle unless rsp_stall holds; the phase and attempt registers
// update in the same cycle as the response register, so beats chain freely.
// When the receiver stalls, the response holds and one more request is held in
// the input register; after that req_stall rises.
// Synchronous reset empties both registers, returns to idle with no attempts
// used, and sets the retry limit to three.
module i2c_dac_write_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  i2cdws_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output i2cdws_pkg::rsp_type rsp_data,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data
);
   import i2cdws_pkg::*;

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic [7:0] try_limit_ff;
   logic    advance;
   logic    step_en;
   rsp_type step_result;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign step_en   = in_valid_ff && advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   i2cdws_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .item      (in_data_ff),
      .try_limit (try_limit_ff),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         try_limit_ff <= TRY_LIMIT_RESET;
      end else begin
         if (csr_wr_en) begin
            try_limit_ff <= csr_wr_data;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
            if (req_valid) begin
               in_data_ff <= req_data;
            end
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               out_data_ff <= step_result;
            end
         end
      end
   end

endmodule

>>> hdl/i2cdws_check.sv
module i2cdws_check (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input i2cdws_pkg::rsp_type rsp_data
);
   import i2cdws_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response beat changed.");

   a_success_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.success |-> rsp_data.done_res && rsp_data.bus_command == CMD_STOP)
      else $error("Success reported without a final stop.");

   a_byte_only_on_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bus_command != CMD_SEND |-> rsp_data.tx_byte == 8'd0)
      else $error("Byte present on a command that sends nothing.");

   a_start_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bus_command == CMD_START |-> !rsp_data.done_res)
      else $error("Start command marked as the end of a transaction.");

endmodule

bind i2c_dac_write_sequencer i2cdws_check u_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
